// File: rtl/atbs_pkg.sv
// Package for the adaptive tick bucket series block.
// Holds sizes, request codes and the item types shared by the modules.
package atbs_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int RES_W = 34;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef struct packed {
        req_t        req;
        logic [31:0] off;
        logic [31:0] ticks;
        logic [4:0]  idx;
    } cmd_t;

    typedef struct packed {
        logic [31:0]      off;
        logic [31:0]      ticks;
        logic             valid;
        logic [5:0]       count;
        logic [RES_W-1:0] res;
        logic             coarse;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SNAP,
        ST_LAST,
        ST_LASTCHK,
        ST_MRD,
        ST_MRD2,
        ST_MWR,
        ST_CRD,
        ST_CSNAP,
        ST_CPREV,
        ST_CWR,
        ST_APPEND,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

// File: rtl/atbs_front.sv
// Front part: accepts items and queues them for the engine.
// Depends on atbs_pkg.
module atbs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          req_type,
    input  logic [31:0]         offset_time,
    input  logic [31:0]         tick_amount,
    input  logic [4:0]          read_index,
    output logic                cmd_valid,
    output atbs_pkg::cmd_t      cmd,
    input  logic                cmd_take
);
    atbs_pkg::cmd_t q_reg [atbs_pkg::QDEPTH];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     n_reg, n_next;
    logic           wr;

    assign full = (n_reg == 2'(atbs_pkg::QDEPTH));
    assign wr = push && !full;
    assign cmd_valid = (n_reg != 2'd0);
    assign cmd = q_reg[rp_reg];

    always_comb
    begin
        wp_next = wr ? ~wp_reg : wp_reg;
        rp_next = cmd_take ? ~rp_reg : rp_reg;
        n_next = n_reg + 2'(wr) - 2'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= {atbs_pkg::req_t'(req_type), offset_time, tick_amount,
                              read_index};
        end
    end
endmodule

// File: rtl/atbs_divider.sv
// Iterative restoring divider computing the snapped offset floor(a/b)*b.
// Depends on atbs_pkg; one quotient bit per cycle, then a multiply into the registered result.
module atbs_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 a,
    input  logic [atbs_pkg::RES_W-1:0]  b,
    output logic                        done,
    output logic [31:0]                 snapped
);
    logic [31:0]                q_reg, q_next;
    logic [atbs_pkg::RES_W:0]   r_reg, r_next;
    logic [atbs_pkg::RES_W-1:0] b_reg, b_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next, mul_reg, mul_next;
    logic [31:0]                s_reg, s_next;
    logic [atbs_pkg::RES_W:0]   sh;
    logic [65:0]                prod;

    assign done = mul_reg;
    assign snapped = s_reg;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        mul_next = 1'b0;
        s_next = s_reg;
        sh = {r_reg[atbs_pkg::RES_W-1:0], q_reg[31]};
        prod = {34'd0, q_reg} * {32'd0, b_reg};
        if (start)
        begin
            q_next = a;
            r_next = '0;
            b_next = b;
            cnt_next = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                mul_next = 1'b1;
                s_next = prod[31:0];
            end
            else
            begin
                if (sh >= {1'b0, b_reg})
                begin
                    r_next = sh - {1'b0, b_reg};
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = sh;
                    q_next = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mul_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            mul_reg <= mul_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        b_reg <= b_next;
        s_reg <= s_next;
    end
endmodule

// File: rtl/atbs_engine.sv
// Back part: bucket table, coarsening sequencer and result queue.
// Depends on atbs_pkg and atbs_divider.
module atbs_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         start_res,
    input  logic                cmd_valid,
    input  atbs_pkg::cmd_t      cmd,
    output logic                cmd_take,
    output logic                rsp_valid,
    output atbs_pkg::rsp_t      rsp,
    input  logic                rsp_take
);
    localparam int IW = atbs_pkg::IDX_W;
    localparam int CW = atbs_pkg::CNT_W;
    localparam int RW = atbs_pkg::RES_W;

    logic [31:0] offs_mem [atbs_pkg::ENTRIES];
    logic [31:0] tick_mem [atbs_pkg::ENTRIES];
    logic [31:0] rd_off_reg, rd_tick_reg;

    atbs_pkg::state_t state_reg, state_next;
    atbs_pkg::cmd_t   c_reg, c_next;
    logic [CW-1:0]    cnt_reg, cnt_next, src_reg, src_next, dst_reg, dst_next;
    logic [RW-1:0]    res_reg, res_next;
    logic             coarse_reg, coarse_next, retry_reg, retry_next;
    logic [31:0]      b_reg, b_next, acc_off_reg, acc_off_next;
    logic [31:0]      acc_t_reg, acc_t_next;
    atbs_pkg::rsp_t   out_reg, out_next;
    logic             ov_reg, ov_next;

    logic             rd_en, wr_en;
    logic [IW-1:0]    rd_addr, wr_addr;
    logic [31:0]      wr_off, wr_tick;
    logic             div_start, div_done;
    logic [31:0]      div_a, div_snap;
    logic [RW:0]      res2;
    logic             hit;

    atbs_divider u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .a       (div_a),
        .b       (res_reg),
        .done    (div_done),
        .snapped (div_snap)
    );

    assign rsp_valid = ov_reg;
    assign rsp = out_reg;
    assign res2 = {res_reg, 1'b0};
    assign hit = (c_reg.req == atbs_pkg::REQ_READ) && (6'(c_reg.idx) < 6'(cnt_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            offs_mem[wr_addr] <= wr_off;
            tick_mem[wr_addr] <= wr_tick;
        end
        if (rd_en)
        begin
            rd_off_reg <= offs_mem[rd_addr];
            rd_tick_reg <= tick_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            atbs_pkg::ST_IDLE:
                if (cmd_valid)
                begin
                    state_next = atbs_pkg::ST_DONE;
                    if (cmd.req == atbs_pkg::REQ_ADD && cmd.ticks != 32'd0 && res_reg != '0)
                        state_next = atbs_pkg::ST_SNAP;
                    else if (cmd.req == atbs_pkg::REQ_READ && 6'(cmd.idx) < 6'(cnt_reg))
                        state_next = atbs_pkg::ST_READ;
                end
            atbs_pkg::ST_SNAP:
                if (div_done)
                    state_next = atbs_pkg::ST_LAST;
            atbs_pkg::ST_LAST:
                state_next = atbs_pkg::ST_LASTCHK;
            atbs_pkg::ST_LASTCHK:
                if (cnt_reg != '0 && rd_off_reg == b_reg)
                    state_next = atbs_pkg::ST_DONE;
                else if (cnt_reg >= CW'(atbs_pkg::ENTRIES) && !retry_reg)
                    state_next = atbs_pkg::ST_MRD;
                else if (cnt_reg < CW'(atbs_pkg::ENTRIES))
                    state_next = atbs_pkg::ST_APPEND;
                else
                    state_next = atbs_pkg::ST_DONE;
            atbs_pkg::ST_MRD:
                state_next = (src_reg >= cnt_reg) ? atbs_pkg::ST_CRD : atbs_pkg::ST_MRD2;
            atbs_pkg::ST_MRD2:
                state_next = atbs_pkg::ST_MWR;
            atbs_pkg::ST_MWR:
                state_next = atbs_pkg::ST_MRD;
            atbs_pkg::ST_CRD:
                if (res_reg == '0)
                    state_next = atbs_pkg::ST_DONE;
                else if (src_reg >= cnt_reg)
                    state_next = atbs_pkg::ST_SNAP;
                else
                    state_next = atbs_pkg::ST_CSNAP;
            atbs_pkg::ST_CSNAP:
                if (div_done)
                    state_next = atbs_pkg::ST_CPREV;
            atbs_pkg::ST_CPREV:
                state_next = atbs_pkg::ST_CWR;
            atbs_pkg::ST_CWR:
                state_next = atbs_pkg::ST_CRD;
            atbs_pkg::ST_APPEND:
                state_next = atbs_pkg::ST_DONE;
            atbs_pkg::ST_READ:
                state_next = atbs_pkg::ST_DONE;
            atbs_pkg::ST_DONE:
                if (!ov_reg || rsp_take)
                    state_next = atbs_pkg::ST_IDLE;
            default:
                state_next = atbs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        c_next = c_reg;
        cnt_next = cnt_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        res_next = res_reg;
        coarse_next = coarse_reg;
        retry_next = retry_reg;
        b_next = b_reg;
        acc_off_next = acc_off_reg;
        acc_t_next = acc_t_reg;
        out_next = out_reg;
        ov_next = ov_reg && !rsp_take;
        cmd_take = 1'b0;
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_off = '0;
        wr_tick = '0;
        div_start = 1'b0;
        div_a = c_reg.off;
        unique case (state_reg)
            atbs_pkg::ST_IDLE:
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    c_next = cmd;
                    retry_next = 1'b0;
                    if (cmd.req == atbs_pkg::REQ_ADD && cmd.ticks != 32'd0 && res_reg != '0)
                    begin
                        div_start = 1'b1;
                        div_a = cmd.off;
                    end
                    else if (cmd.req == atbs_pkg::REQ_READ)
                    begin
                        rd_en = 1'b1;
                        rd_addr = cmd.idx[IW-1:0];
                    end
                    else if (cmd.req == atbs_pkg::REQ_CLEAR)
                    begin
                        cnt_next = '0;
                        res_next = RW'(start_res);
                        coarse_next = 1'b0;
                    end
                end
            atbs_pkg::ST_SNAP:
                if (div_done)
                begin
                    b_next = div_snap;
                    rd_en = 1'b1;
                    rd_addr = IW'(cnt_reg - CW'(1));
                end
            atbs_pkg::ST_LAST:
                ;
            atbs_pkg::ST_LASTCHK:
                if (cnt_reg != '0 && rd_off_reg == b_reg)
                begin
                    wr_en = 1'b1;
                    wr_addr = IW'(cnt_reg - CW'(1));
                    wr_off = b_reg;
                    wr_tick = rd_tick_reg + c_reg.ticks;
                end
                else if (cnt_reg >= CW'(atbs_pkg::ENTRIES) && !retry_reg)
                begin
                    src_next = '0;
                    dst_next = '0;
                    retry_next = 1'b1;
                end
            atbs_pkg::ST_MRD:
                if (src_reg >= cnt_reg)
                begin
                    cnt_next = dst_reg;
                    res_next = res2[RW-1:0];
                    coarse_next = 1'b1;
                    src_next = '0;
                    dst_next = '0;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = src_reg[IW-1:0];
                end
            atbs_pkg::ST_MRD2:
            begin
                acc_off_next = rd_off_reg;
                acc_t_next = rd_tick_reg;
                if (src_reg + CW'(1) < cnt_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = IW'(src_reg + CW'(1));
                end
            end
            atbs_pkg::ST_MWR:
            begin
                wr_en = 1'b1;
                wr_addr = dst_reg[IW-1:0];
                wr_off = acc_off_reg;
                wr_tick = (src_reg + CW'(1) < cnt_reg) ? acc_t_reg + rd_tick_reg : acc_t_reg;
                dst_next = dst_reg + CW'(1);
                src_next = src_reg + CW'(2);
            end
            atbs_pkg::ST_CRD:
                if (res_reg != '0)
                begin
                    if (src_reg >= cnt_reg)
                    begin
                        cnt_next = dst_reg;
                        div_start = 1'b1;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        rd_addr = src_reg[IW-1:0];
                    end
                end
            atbs_pkg::ST_CSNAP:
                if (div_done)
                begin
                    b_next = div_snap;
                    rd_en = (dst_reg != '0);
                    rd_addr = IW'(dst_reg - CW'(1));
                end
            atbs_pkg::ST_CPREV:
                ;
            atbs_pkg::ST_CWR:
            begin
                wr_en = 1'b1;
                if (dst_reg != '0 && rd_off_reg == b_reg)
                begin
                    wr_addr = IW'(dst_reg - CW'(1));
                    wr_off = b_reg;
                    wr_tick = rd_tick_reg + acc_t_reg;
                end
                else
                begin
                    wr_addr = dst_reg[IW-1:0];
                    wr_off = b_reg;
                    wr_tick = acc_t_reg;
                    dst_next = dst_reg + CW'(1);
                end
                src_next = src_reg + CW'(1);
            end
            atbs_pkg::ST_APPEND:
            begin
                wr_en = 1'b1;
                wr_addr = cnt_reg[IW-1:0];
                wr_off = b_reg;
                wr_tick = c_reg.ticks;
                cnt_next = cnt_reg + CW'(1);
            end
            atbs_pkg::ST_READ:
                ;
            atbs_pkg::ST_DONE:
                if (!ov_reg || rsp_take)
                begin
                    ov_next = 1'b1;
                    out_next.off = hit ? rd_off_reg : 32'd0;
                    out_next.ticks = hit ? rd_tick_reg : 32'd0;
                    out_next.valid = hit;
                    out_next.count = 6'(cnt_reg);
                    out_next.res = res_reg;
                    out_next.coarse = coarse_reg;
                end
            default:
                ;
        endcase
        // The source entry's ticks arrive in the cycle after ST_CRD.
        if (state_reg == atbs_pkg::ST_CRD && res_reg != '0 && src_reg < cnt_reg)
            acc_off_next = 32'd1;
        if (state_reg == atbs_pkg::ST_CSNAP && acc_off_reg == 32'd1)
        begin
            div_start = 1'b1;
            div_a = rd_off_reg;
            acc_t_next = rd_tick_reg;
            acc_off_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atbs_pkg::ST_IDLE;
            cnt_reg <= '0;
            res_reg <= '0;
            coarse_reg <= 1'b0;
            ov_reg <= 1'b0;
            acc_off_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            res_reg <= res_next;
            coarse_reg <= coarse_next;
            ov_reg <= ov_next;
            acc_off_reg <= acc_off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        src_reg <= src_next;
        dst_reg <= dst_next;
        retry_reg <= retry_next;
        b_reg <= b_next;
        acc_t_reg <= acc_t_next;
        out_reg <= out_next;
    end
endmodule

// File: rtl/adaptive_tick_bucket_series.sv
// Top level of the adaptive tick bucket series block.
// Depends on atbs_pkg, atbs_front and atbs_engine.
//
// channel | direction | handshake        | fields
// input   | in        | push / full      | req_type offset_time tick_amount read_index
// result  | out       | empty / pop      | entry_offset entry_ticks entry_valid entry_count
//         |           |                  | resolution_now was_coarsened
// config  | in        | cfg_we           | cfg_wdata (start_resolution)
//
// A read, clear or ignored item needs no division; an add waits on the snap division.
// A coarsening pass walks the table twice, with one division per entry in the collapse walk.
// Reset clears counts, resolution and flags; the table needs no clearing.
// A full result register stalls the engine, and the front queue then holds up to two items.
module adaptive_tick_bucket_series
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [31:0] offset_time,
    input  logic [31:0] tick_amount,
    input  logic [4:0]  read_index,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] entry_offset,
    output logic [31:0] entry_ticks,
    output logic        entry_valid,
    output logic [5:0]  entry_count,
    output logic [33:0] resolution_now,
    output logic        was_coarsened
);
    logic [31:0]    start_res_reg;
    logic           cmd_valid, cmd_take, rsp_valid;
    atbs_pkg::cmd_t cmd;
    atbs_pkg::rsp_t rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_res_reg <= '0;
        else if (cfg_we)
            start_res_reg <= cfg_wdata;
    end

    atbs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .offset_time (offset_time),
        .tick_amount (tick_amount),
        .read_index  (read_index),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take)
    );

    atbs_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_res (start_res_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rsp_take  (pop && rsp_valid)
    );

    assign empty = !rsp_valid;
    assign entry_offset = rsp.off;
    assign entry_ticks = rsp.ticks;
    assign entry_valid = rsp.valid;
    assign entry_count = rsp.count;
    assign resolution_now = rsp.res;
    assign was_coarsened = rsp.coarse;
endmodule

// File: bench/adaptive_tick_bucket_series_test.sv
// Self-checking testbench for the adaptive tick bucket series block.
// Depends on atbs_pkg and adaptive_tick_bucket_series; drives directed rows, then random phases.
`timescale 1ns / 1ps
module adaptive_tick_bucket_series_test;

    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        bit               wcfg;
        logic [31:0]      cfgv;
        atbs_pkg::req_t   req;
        logic [31:0]      off;
        logic [31:0]      ticks;
        logic [4:0]       idx;
        bit               lit;
        atbs_pkg::rsp_t   want;
    } row_t;

    typedef enum int {PAT_ASCEND, PAT_SPREAD, PAT_EXTREME} pattern_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  req_type = '0;
    logic [31:0] offset_time = '0;
    logic [31:0] tick_amount = '0;
    logic [4:0]  read_index = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] entry_offset;
    logic [31:0] entry_ticks;
    logic        entry_valid;
    logic [5:0]  entry_count;
    logic [33:0] resolution_now;
    logic        was_coarsened;

    logic [31:0] bkt_off [atbs_pkg::ENTRIES];
    logic [31:0] bkt_tick [atbs_pkg::ENTRIES];
    int          bkt_used;
    logic [33:0] live_res;
    bit          coarse_seen;
    logic [31:0] start_res;

    atbs_pkg::rsp_t pending_results [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_request = 0;

    adaptive_tick_bucket_series dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .push(push), .full(full), .req_type(req_type), .offset_time(offset_time),
        .tick_amount(tick_amount), .read_index(read_index), .empty(empty), .pop(pop),
        .entry_offset(entry_offset), .entry_ticks(entry_ticks), .entry_valid(entry_valid),
        .entry_count(entry_count), .resolution_now(resolution_now),
        .was_coarsened(was_coarsened)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] snap(logic [31:0] off, logic [33:0] res);
        logic [63:0] q;
        q = (64'(off) / 64'(res)) * 64'(res);
        return q[31:0];
    endfunction

    function automatic void coarsen_buckets();
        int dst;
        logic [31:0] b;
        dst = 0;
        for (int src = 0; src < bkt_used; src += 2)
        begin
            bkt_tick[dst] = bkt_tick[src];
            if (src + 1 < bkt_used)
                bkt_tick[dst] = bkt_tick[dst] + bkt_tick[src + 1];
            bkt_off[dst] = bkt_off[src];
            dst++;
        end
        bkt_used = dst;
        live_res = live_res << 1;
        coarse_seen = 1'b1;
        if (live_res == 0)
            return;
        dst = 0;
        for (int src = 0; src < bkt_used; src++)
        begin
            b = snap(bkt_off[src], live_res);
            if (dst > 0 && bkt_off[dst - 1] == b)
                bkt_tick[dst - 1] = bkt_tick[dst - 1] + bkt_tick[src];
            else
            begin
                bkt_off[dst] = b;
                bkt_tick[dst] = bkt_tick[src];
                dst++;
            end
        end
        bkt_used = dst;
    endfunction

    function automatic void record_ticks(logic [31:0] off, logic [31:0] ticks);
        logic [31:0] b;
        if (ticks == 0 || live_res == 0)
            return;
        b = snap(off, live_res);
        if (bkt_used > 0 && bkt_off[bkt_used - 1] == b)
        begin
            bkt_tick[bkt_used - 1] = bkt_tick[bkt_used - 1] + ticks;
            return;
        end
        if (bkt_used >= atbs_pkg::ENTRIES)
        begin
            coarsen_buckets();
            if (live_res == 0)
                return;
            b = snap(off, live_res);
            if (bkt_used > 0 && bkt_off[bkt_used - 1] == b)
            begin
                bkt_tick[bkt_used - 1] = bkt_tick[bkt_used - 1] + ticks;
                return;
            end
        end
        if (bkt_used < atbs_pkg::ENTRIES)
        begin
            bkt_off[bkt_used] = b;
            bkt_tick[bkt_used] = ticks;
            bkt_used++;
        end
    endfunction

    function automatic atbs_pkg::rsp_t predict_series(atbs_pkg::req_t req, logic [31:0] off,
                                                      logic [31:0] ticks, logic [4:0] idx);
        atbs_pkg::rsp_t r;
        r = '0;
        case (req)
            atbs_pkg::REQ_ADD: record_ticks(off, ticks);
            atbs_pkg::REQ_READ:
                if (idx < bkt_used)
                begin
                    r.off = bkt_off[idx];
                    r.ticks = bkt_tick[idx];
                    r.valid = 1'b1;
                end
            atbs_pkg::REQ_CLEAR:
            begin
                bkt_used = 0;
                live_res = 34'(start_res);
                coarse_seen = 1'b0;
            end
            default: ;
        endcase
        r.count = 6'(bkt_used);
        r.res = live_res;
        r.coarse = coarse_seen;
        return r;
    endfunction

    task automatic send_item(atbs_pkg::req_t req, logic [31:0] off, logic [31:0] ticks,
                             logic [4:0] idx, bit lit, atbs_pkg::rsp_t want);
        atbs_pkg::rsp_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req_type <= req;
        offset_time <= off;
        tick_amount <= ticks;
        read_index <= idx;
        @(posedge clk);
        while (full)
            @(posedge clk);
        r = predict_series(req, off, ticks, idx);
        pending_results.push_back(lit ? want : r);
    endtask

    task automatic write_start_res(logic [31:0] v);
        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        start_res = v;
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            pop <= 1'b0;
            hold_request <= hold_request - 1;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        atbs_pkg::rsp_t w;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no expectation waiting");
                fail_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (entry_offset !== w.off)
                begin
                    $error("entry_offset expected %0h actual %0h", w.off, entry_offset);
                    fail_count++;
                end
                if (entry_ticks !== w.ticks)
                begin
                    $error("entry_ticks expected %0h actual %0h", w.ticks, entry_ticks);
                    fail_count++;
                end
                if (entry_valid !== w.valid)
                begin
                    $error("entry_valid expected %0h actual %0h", w.valid, entry_valid);
                    fail_count++;
                end
                if (entry_count !== w.count)
                begin
                    $error("entry_count expected %0d actual %0d", w.count, entry_count);
                    fail_count++;
                end
                if (resolution_now !== w.res)
                begin
                    $error("resolution_now expected %0h actual %0h", w.res, resolution_now);
                    fail_count++;
                end
                if (was_coarsened !== w.coarse)
                begin
                    $error("was_coarsened expected %0h actual %0h", w.coarse, was_coarsened);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        row_t           rows [14];
        logic [31:0]    starts [8];
        pattern_t       pats [8];
        int             counts [8];
        logic [31:0]    cursor;
        logic [31:0]    off;
        logic [31:0]    ticks;
        logic [4:0]     idx;
        int             pick;
        atbs_pkg::req_t req;

        for (int i = 0; i < atbs_pkg::ENTRIES; i++)
        begin
            bkt_off[i] = '0;
            bkt_tick[i] = '0;
        end
        bkt_used = 0;
        live_res = '0;
        coarse_seen = 1'b0;
        start_res = '0;

        rows[0]  = '{0, 0, atbs_pkg::REQ_READ, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0}};
        rows[1]  = '{0, 0, atbs_pkg::REQ_ADD, 5, 7, 0, 1, '{0, 0, 0, 0, 0, 0}};
        rows[2]  = '{0, 0, atbs_pkg::REQ_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 31, 1,
                     '{0, 0, 0, 0, 0, 0}};
        rows[3]  = '{1, 10, atbs_pkg::REQ_CLEAR, 0, 0, 0, 1, '{0, 0, 0, 0, 10, 0}};
        rows[4]  = '{0, 0, atbs_pkg::REQ_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, '0};
        rows[5]  = '{0, 0, atbs_pkg::REQ_ADD, 32'hFFFFFFFA, 2, 0, 0, '0};
        rows[6]  = '{0, 0, atbs_pkg::REQ_ADD, 0, 0, 0, 0, '0};
        rows[7]  = '{0, 0, atbs_pkg::REQ_READ, 0, 0, 31, 1, '{0, 0, 0, 1, 10, 0}};
        rows[8]  = '{1, 20, atbs_pkg::REQ_READ, 0, 0, 0, 0, '0};
        rows[9]  = '{0, 0, atbs_pkg::REQ_ADD, 0, 1, 0, 0, '0};
        rows[10] = '{0, 0, atbs_pkg::REQ_READ, 0, 0, 1, 0, '0};
        rows[11] = '{0, 0, atbs_pkg::REQ_CLEAR, 0, 0, 0, 0, '0};
        rows[12] = '{1, 32'hFFFFFFFF, atbs_pkg::REQ_CLEAR, 0, 0, 0, 1,
                     '{0, 0, 0, 0, 32'hFFFFFFFF, 0}};
        rows[13] = '{0, 0, atbs_pkg::REQ_ADD, 32'hFFFFFFFE, 3, 0, 0, '0};

        starts = '{1, 0, 3, 32'hFFFFFFFF, 32'h80000000, 7, 1, 100};
        pats = '{PAT_ASCEND, PAT_SPREAD, PAT_SPREAD, PAT_EXTREME, PAT_SPREAD, PAT_ASCEND,
                 PAT_SPREAD, PAT_ASCEND};
        counts = '{150, 60, 150, 140, 120, 150, 180, 150};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].wcfg)
                write_start_res(rows[i].cfgv);
            send_item(rows[i].req, rows[i].off, rows[i].ticks, rows[i].idx, rows[i].lit,
                      rows[i].want);
        end

        for (int p = 0; p < 8; p++)
        begin
            write_start_res(starts[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (p == 2)
            begin
                send_idle_pct = 0;
                hold_request = 400;
            end
            cursor = $urandom;
            send_item(atbs_pkg::REQ_CLEAR, 0, 0, 0, 0, '0);
            for (int n = 0; n < counts[p]; n++)
            begin
                if (p == 2 && n == 40)
                    recv_stall_pct = 80;
                pick = $urandom_range(99);
                req = (pick < 65) ? atbs_pkg::REQ_ADD :
                      (pick < 92) ? atbs_pkg::REQ_READ :
                      (pick < 95) ? atbs_pkg::REQ_CLEAR : atbs_pkg::REQ_NONE;
                case (pats[p])
                    PAT_ASCEND:
                    begin
                        cursor = cursor + $urandom_range(0, 64);
                        off = cursor;
                    end
                    PAT_SPREAD: off = $urandom;
                    default: off = ($urandom_range(3) == 0) ? $urandom :
                                   ($urandom_range(1) ? 32'hFFFFFFFF : 32'h0);
                endcase
                pick = $urandom_range(99);
                ticks = (pick < 80) ? $urandom_range(1, 1000) : (pick < 90) ? $urandom :
                        (pick < 95) ? 32'h0 : 32'hFFFFFFFF;
                if (bkt_used > 0 && $urandom_range(99) < 70)
                    idx = 5'($urandom_range(0, bkt_used - 1));
                else
                    idx = 5'($urandom_range(31));
                send_item(req, off, ticks, idx, 0, '0);
            end
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
rtl/atbs_pkg.sv
rtl/atbs_front.sv
rtl/atbs_divider.sv
rtl/atbs_engine.sv
rtl/adaptive_tick_bucket_series.sv
bench/adaptive_tick_bucket_series_test.sv
